// ----- rtl/core/rmat_pkg.sv -----
// Shared constants, codes and record types of the reliable message acknowledgement tracker.
// No dependencies; every module file of the block imports this package.
package rmat_pkg;

   localparam int TABLE_DEPTH  = 16;
   localparam int MAX_PEERS    = 16;
   localparam int RESULT_LIMIT = 16;
   localparam int IDX_W        = $clog2(TABLE_DEPTH);
   localparam int RCNT_W       = $clog2(RESULT_LIMIT + 1);
   localparam int CNT_W        = 28;

   localparam logic [1:0] OP_SEND     = 2'd0;
   localparam logic [1:0] OP_REMEMBER = 2'd1;
   localparam logic [1:0] OP_ACK      = 2'd2;
   localparam logic [1:0] OP_TICK     = 2'd3;

   localparam logic [3:0] KIND_ADDED       = 4'd0;
   localparam logic [3:0] KIND_KNOWN       = 4'd1;
   localparam logic [3:0] KIND_FULL        = 4'd2;
   localparam logic [3:0] KIND_ACK_PENDING = 4'd3;
   localparam logic [3:0] KIND_ACK_DONE    = 4'd4;
   localparam logic [3:0] KIND_NOT_FOUND   = 4'd5;
   localparam logic [3:0] KIND_RESEND      = 4'd6;
   localparam logic [3:0] KIND_DISCONNECT  = 4'd7;
   localparam logic [3:0] KIND_IDLE        = 4'd8;

   localparam logic [2:0] CSR_LOCAL_PLAYER  = 3'd0;
   localparam logic [2:0] CSR_PLAYER_COUNT  = 3'd1;
   localparam logic [2:0] CSR_KEEP_TIMEOUT  = 3'd2;
   localparam logic [2:0] CSR_RESEND_INTVL  = 3'd3;
   localparam logic [2:0] CSR_COMPETITION   = 3'd4;

   typedef struct packed {
      logic [3:0]  local_player;
      logic [15:0] limit_mask;
      logic [15:0] keep_timeout;
      logic [15:0] resend_interval;
      logic        competition_mode;
   } cfg_type;

   typedef struct packed {
      logic        is_sent;
      logic [31:0] id;
      logic [15:0] pending;
      logic [31:0] created;
      logic [31:0] resent;
   } entry_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      entry_type        wdata;
      logic [IDX_W-1:0] raddr;
   } mem_req_type;

endpackage

// ----- rtl/core/rmat_if.sv -----
// Valid/ready channel interfaces for request and response beats of the tracker.
// No dependencies.
interface rmat_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] msg_id;
   logic [3:0]  player;
   logic [15:0] connected_mask;
   logic [31:0] now;
   modport source(output valid, op, msg_id, player, connected_mask, now, input ready);
   modport sink(input valid, op, msg_id, player, connected_mask, now, output ready);
endinterface

interface rmat_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  kind;
   logic [31:0] msg_id_res;
   logic [15:0] peer_mask;
   logic        last;
   modport source(output valid, kind, msg_id_res, peer_mask, last, input ready);
   modport sink(input valid, kind, msg_id_res, peer_mask, last, output ready);
endinterface

// ----- rtl/core/reliable_message_ack_tracker.sv -----
// Reliable message acknowledgement tracker: a 16-entry table of sent messages awaiting
// acknowledgement and of received ids kept for duplicate detection. Ready is high only
// between requests. A send allocates a free entry, if any, and answers. Remember,
// acknowledge and tick read one table entry per step through the single read port of
// the entry memory, then give the final beat; remember and acknowledge stop at the first
// matching entry, and an acknowledge from the local player or for a foreign id skips the
// read. A tick emits up to 16 response beats, the last one flagged; it holds while the
// response side stalls. Depends on rmat_pkg, rmat_if, rmat_csr, rmat_mem and rmat_ctrl.
module reliable_message_ack_tracker import rmat_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   rmat_req_if.sink    req_bus,
   rmat_rsp_if.source  rsp_bus
);

   cfg_type     cfg;
   mem_req_type mem_req;
   entry_type   rd_data;

   rmat_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rmat_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   rmat_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

// ----- rtl/core/rmat_csr.sv -----
// Configuration registers of the tracker and the derived peer limit mask.
// Depends on rmat_pkg.
module rmat_csr import rmat_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output cfg_type     cfg
);

   logic [3:0]  lp_ff;
   logic [4:0]  pc_ff;
   logic [15:0] keep_ff;
   logic [15:0] resend_ff;
   logic        comp_ff;
   logic [15:0] limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_ff     <= 4'd0;
         pc_ff     <= 5'd16;
         keep_ff   <= 16'd5000;
         resend_ff <= 16'd300;
         comp_ff   <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LOCAL_PLAYER: lp_ff     <= csr_wdata[3:0];
            CSR_PLAYER_COUNT: pc_ff     <= csr_wdata[4:0];
            CSR_KEEP_TIMEOUT: keep_ff   <= csr_wdata;
            CSR_RESEND_INTVL: resend_ff <= csr_wdata;
            CSR_COMPETITION:  comp_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int b = 0; b < 16; b++) begin
         limit[b] = (5'(b) < pc_ff) && (b < MAX_PEERS);
      end
   end

   assign cfg.local_player     = lp_ff;
   assign cfg.limit_mask       = limit;
   assign cfg.keep_timeout     = keep_ff;
   assign cfg.resend_interval  = resend_ff;
   assign cfg.competition_mode = comp_ff;

endmodule

// ----- rtl/core/rmat_mem.sv -----
// Entry record memory: one write port and one read port with registered read data.
// Depends on rmat_pkg.
module rmat_mem import rmat_pkg::*; (
   input  logic        clock,
   input  mem_req_type mem_req,
   output entry_type   rd_data
);

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rd_data_ff <= mem[mem_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/rmat_ctrl.sv -----
// Sequencer of the tracker: accepts a request, walks the entry memory, writes back and
// drives response beats. Depends on rmat_pkg and rmat_if.
module rmat_ctrl import rmat_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   rmat_req_if.sink    req_bus,
   rmat_rsp_if.source  rsp_bus,
   output mem_req_type mem_req,
   input  entry_type   rd_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WALK = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [1:0]             op_ff, op_in;
   logic [31:0]            msg_ff, msg_in;
   logic [3:0]             player_ff, player_in;
   logic [15:0]            conn_ff, conn_in;
   logic [31:0]            now_ff, now_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   found_ff, found_in;
   logic [3:0]             res_kind_ff, res_kind_in;
   logic [15:0]            res_mask_ff, res_mask_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       counter_ff, counter_in;
   logic                   hold_vld_ff, hold_vld_in;
   logic [3:0]             hold_kind_ff, hold_kind_in;
   logic [31:0]            hold_id_ff, hold_id_in;
   logic [15:0]            hold_mask_ff, hold_mask_in;
   logic [RCNT_W-1:0]      cnt_ff, cnt_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   logic [3:0]             rsp_kind_ff, rsp_kind_in;
   logic [31:0]            rsp_id_ff, rsp_id_in;
   logic [15:0]            rsp_mask_ff, rsp_mask_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   out_free;
   logic                   has_free;
   logic [IDX_W-1:0]       free_idx;
   logic                   ent_v;
   logic                   last_idx;
   logic [31:0]            age_created;
   logic [31:0]            age_resent;
   logic                   live;
   logic                   due;
   logic [15:0]            rep;
   logic                   report;
   logic [3:0]             rep_kind;
   logic [15:0]            new_pend;
   logic [CNT_W-1:0]       next_count;

   assign out_free    = !rsp_vld_ff || rsp_bus.ready;
   assign has_free    = ~&valid_ff;
   assign ent_v       = valid_ff[idx_ff];
   assign last_idx    = idx_ff == IDX_W'(TABLE_DEPTH - 1);
   assign age_created = now_ff - rd_data.created;
   assign age_resent  = now_ff - rd_data.resent;
   assign live        = age_created < {16'd0, cfg.keep_timeout};
   assign due         = age_resent >= {16'd0, cfg.resend_interval};
   assign rep         = rd_data.pending & cfg.limit_mask;
   assign new_pend    = rd_data.pending & ~(16'd1 << player_ff);
   assign next_count  = counter_ff + 1'b1;

   always_comb begin
      free_idx = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      report   = 1'b0;
      rep_kind = KIND_RESEND;
      if (ent_v && rd_data.pending != 16'd0) begin
         if (live) begin
            report = due && rd_data.is_sent && rep != 16'd0;
         end else begin
            report   = rd_data.is_sent && cfg.competition_mode && rep != 16'd0;
            rep_kind = KIND_DISCONNECT;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      msg_in       = msg_ff;
      player_in    = player_ff;
      conn_in      = conn_ff;
      now_in       = now_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      res_kind_in  = res_kind_ff;
      res_mask_in  = res_mask_ff;
      valid_in     = valid_ff;
      counter_in   = counter_ff;
      hold_vld_in  = hold_vld_ff;
      hold_kind_in = hold_kind_ff;
      hold_id_in   = hold_id_ff;
      hold_mask_in = hold_mask_ff;
      cnt_in       = cnt_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_bus.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_last_in  = rsp_last_ff;
      mem_req.we    = 1'b0;
      mem_req.waddr = idx_ff;
      mem_req.wdata = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               op_in       = req_bus.op;
               msg_in      = req_bus.msg_id;
               player_in   = req_bus.player;
               conn_in     = req_bus.connected_mask;
               now_in      = req_bus.now;
               idx_in      = '0;
               found_in    = 1'b0;
               hold_vld_in = 1'b0;
               cnt_in      = '0;
               res_kind_in = KIND_NOT_FOUND;
               res_mask_in = 16'd0;
               state_in    = S_WALK;
               if (req_bus.op == OP_SEND) begin
                  state_in = S_FIN;
               end else if (req_bus.op == OP_ACK &&
                            (req_bus.player == cfg.local_player ||
                             req_bus.msg_id[31:28] != cfg.local_player)) begin
                  state_in = S_FIN;
               end
            end
         end
         S_WALK: begin
            case (op_ff)
               OP_REMEMBER: begin
                  if (ent_v && !rd_data.is_sent && rd_data.id == msg_ff) begin
                     found_in = 1'b1;
                     state_in = S_FIN;
                  end else if (last_idx) begin
                     state_in = S_FIN;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               OP_ACK: begin
                  if (ent_v && rd_data.is_sent && rd_data.id == msg_ff) begin
                     mem_req.we            = 1'b1;
                     mem_req.wdata.pending = new_pend;
                     if (new_pend == 16'd0) begin
                        valid_in[idx_ff] = 1'b0;
                        res_kind_in      = KIND_ACK_DONE;
                        res_mask_in      = 16'd0;
                     end else begin
                        res_kind_in = KIND_ACK_PENDING;
                        res_mask_in = new_pend;
                     end
                     state_in = S_FIN;
                  end else if (last_idx) begin
                     state_in = S_FIN;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               default: begin
                  if (!(report && hold_vld_ff && !out_free)) begin
                     if (ent_v) begin
                        if (rd_data.pending == 16'd0 || !live) begin
                           valid_in[idx_ff] = 1'b0;
                        end else if (due) begin
                           mem_req.we           = 1'b1;
                           mem_req.wdata.resent = now_ff;
                        end
                     end
                     if (report) begin
                        if (hold_vld_ff) begin
                           rsp_vld_in  = 1'b1;
                           rsp_kind_in = hold_kind_ff;
                           rsp_id_in   = hold_id_ff;
                           rsp_mask_in = hold_mask_ff;
                           rsp_last_in = 1'b0;
                        end
                        hold_vld_in  = 1'b1;
                        hold_kind_in = rep_kind;
                        hold_id_in   = rd_data.id;
                        hold_mask_in = rep;
                        cnt_in       = cnt_ff + 1'b1;
                     end
                     if ((report && cnt_ff + 1'b1 == RCNT_W'(RESULT_LIMIT)) || last_idx) begin
                        state_in = S_FIN;
                     end else begin
                        idx_in = idx_ff + 1'b1;
                     end
                  end
               end
            endcase
         end
         S_FIN: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_last_in = 1'b1;
               rsp_mask_in = 16'd0;
               rsp_id_in   = msg_ff;
               state_in    = S_IDLE;
               case (op_ff)
                  OP_SEND: begin
                     rsp_kind_in = KIND_FULL;
                     rsp_id_in   = 32'd0;
                     if (has_free) begin
                        counter_in              = next_count;
                        valid_in[free_idx]      = 1'b1;
                        mem_req.we              = 1'b1;
                        mem_req.waddr           = free_idx;
                        mem_req.wdata.is_sent   = 1'b1;
                        mem_req.wdata.id        = {cfg.local_player, next_count};
                        mem_req.wdata.pending   = conn_ff & cfg.limit_mask &
                                                  ~(16'd1 << cfg.local_player);
                        mem_req.wdata.created   = now_ff;
                        mem_req.wdata.resent    = now_ff;
                        rsp_kind_in             = KIND_ADDED;
                        rsp_id_in               = {cfg.local_player, next_count};
                        rsp_mask_in             = mem_req.wdata.pending;
                     end
                  end
                  OP_REMEMBER: begin
                     if (found_ff) begin
                        rsp_kind_in = KIND_KNOWN;
                     end else if (has_free) begin
                        valid_in[free_idx]    = 1'b1;
                        mem_req.we            = 1'b1;
                        mem_req.waddr         = free_idx;
                        mem_req.wdata.is_sent = 1'b0;
                        mem_req.wdata.id      = msg_ff;
                        mem_req.wdata.pending = 16'd0;
                        mem_req.wdata.created = now_ff;
                        mem_req.wdata.resent  = now_ff;
                        rsp_kind_in           = KIND_ADDED;
                     end else begin
                        rsp_kind_in = KIND_FULL;
                     end
                  end
                  OP_ACK: begin
                     rsp_kind_in = res_kind_ff;
                     rsp_mask_in = res_mask_ff;
                  end
                  default: begin
                     if (hold_vld_ff) begin
                        rsp_kind_in = hold_kind_ff;
                        rsp_id_in   = hold_id_ff;
                        rsp_mask_in = hold_mask_ff;
                     end else begin
                        rsp_kind_in = KIND_IDLE;
                        rsp_id_in   = 32'd0;
                     end
                     hold_vld_in = 1'b0;
                  end
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase

      mem_req.raddr = idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         valid_ff    <= '0;
         counter_ff  <= '0;
         hold_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         cnt_ff      <= '0;
         idx_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         counter_ff  <= counter_in;
         hold_vld_ff <= hold_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         cnt_ff      <= cnt_in;
         idx_ff      <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      msg_ff       <= msg_in;
      player_ff    <= player_in;
      conn_ff      <= conn_in;
      now_ff       <= now_in;
      found_ff     <= found_in;
      res_kind_ff  <= res_kind_in;
      res_mask_ff  <= res_mask_in;
      hold_kind_ff <= hold_kind_in;
      hold_id_ff   <= hold_id_in;
      hold_mask_ff <= hold_mask_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_bus.ready      = state_ff == S_IDLE;
   assign rsp_bus.valid      = rsp_vld_ff;
   assign rsp_bus.kind       = rsp_kind_ff;
   assign rsp_bus.msg_id_res = rsp_id_ff;
   assign rsp_bus.peer_mask  = rsp_mask_ff;
   assign rsp_bus.last       = rsp_last_ff;

endmodule
